// ----- sv/sirt_pkg.sv -----
// Shared types, constants and helpers for the radix text converter.
// No dependencies; used by every module of the block.
`default_nettype none

package sirt_pkg;

	localparam int MAX_SYMBOLS_DEF = 16;
	localparam int NUM_W = 32;
	localparam int RADIX_W = 5;
	localparam int SYM_W = 8;
	localparam int SYM_IDX_W = 4;
	localparam int ALPHA_W = 128;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam int STORE_DEPTH = 32;
	localparam int STORE_AW = 5;
	localparam int CNT_W = 6;
	localparam int BITS_PER_STEP = 8;
	localparam int STEPS_PER_DIGIT = NUM_W / BITS_PER_STEP;
	localparam int GRP_W = 2;

	localparam logic [SYM_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX  = 2'd0,
		REG_SYM_LO = 2'd1,
		REG_SYM_HI = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_DIGITS,
		ST_REJECT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic digit_end;
		logic emit_sign;
		logic emit_digit;
		logic emit_bad;
	} dp_cmd_t;

	typedef struct packed {
		logic neg;
		logic div_last;
		logic emit_last;
	} dp_stat_t;

	function automatic logic [SYM_W-1:0] symbol_at(input logic [ALPHA_W-1:0] alpha,
			input logic [SYM_IDX_W-1:0] idx);
		symbol_at = alpha[idx*SYM_W +: SYM_W];
	endfunction

endpackage

`default_nettype wire

// ----- sv/signed_integer_to_radix_text.sv -----
// Top level of the signed integer to radix text converter.
// Depends on sirt_pkg, sirt_cfg, sirt_ctrl and sirt_dp.
//
// A request is taken when start is high and busy is low. The number is written
// out in base radix using the configured alphabet, most significant character
// first, one character per strobe cycle with '-' leading for negatives; the
// strobed characters of one number come in consecutive cycles and cannot be
// held off, so the receiver must take each in the cycle it appears. A base
// outside 2..MAX_SYMBOLS or a bad alphabet gives a single strobe with
// bad_alphabet set, registered from the reject state that the request leads
// to. Otherwise the divider splits off one digit at a time (8 quotient bits
// per cycle) until the quotient is zero or the digit store is full; then the
// characters are strobed out, the sign first if negative. busy drops
// as the final character is registered; a new request may follow at once.
// Configuration is written through cfg_valid/cfg_ready while the block is idle.
`default_nettype none

module signed_integer_to_radix_text #(
	parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic signed [sirt_pkg::NUM_W-1:0] number,
	output logic                                  strobe,
	output logic      [sirt_pkg::SYM_W-1:0]       text_char,
	output logic                                  last_char,
	output logic                                  bad_alphabet,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sirt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sirt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [sirt_pkg::RADIX_W-1:0] radix;
	logic [sirt_pkg::ALPHA_W-1:0] alpha;
	logic                         alpha_ok;
	sirt_pkg::dp_cmd_t            cmd;
	sirt_pkg::dp_stat_t           stat;

	assign cfg_ready = !busy;

	sirt_cfg #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.radix    (radix),
		.alpha    (alpha),
		.alpha_ok (alpha_ok)
	);

	sirt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.alpha_ok (alpha_ok),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	sirt_dp #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.number       (number),
		.radix        (radix),
		.alpha        (alpha),
		.stat         (stat),
		.strobe       (strobe),
		.text_char    (text_char),
		.last_char    (last_char),
		.bad_alphabet (bad_alphabet)
	);

endmodule

`default_nettype wire

// ----- sv/sirt_cfg.sv -----
// Configuration registers (radix, alphabet) and the alphabet validity check.
// Depends on sirt_pkg.
`default_nettype none

module sirt_cfg #(
	parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [sirt_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [sirt_pkg::CFG_DATA_W-1:0]  wr_data,
	output logic      [sirt_pkg::RADIX_W-1:0]     radix,
	output logic      [sirt_pkg::ALPHA_W-1:0]     alpha,
	output logic                                  alpha_ok
);

	logic [sirt_pkg::RADIX_W-1:0]    radix_q;
	logic [sirt_pkg::CFG_DATA_W-1:0] sym_lo_q;
	logic [sirt_pkg::CFG_DATA_W-1:0] sym_hi_q;
	logic                            sym_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= '0;
			sym_lo_q <= '0;
			sym_hi_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				sirt_pkg::REG_RADIX:  radix_q  <= wr_data[sirt_pkg::RADIX_W-1:0];
				sirt_pkg::REG_SYM_LO: sym_lo_q <= wr_data;
				sirt_pkg::REG_SYM_HI: sym_hi_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign radix = radix_q;
	assign alpha = {sym_hi_q, sym_lo_q};

	// pairwise compare over the used entries only; a used entry of zero, '+' or '-' is also bad
	always_comb begin
		logic [sirt_pkg::SYM_W-1:0] si;
		logic [sirt_pkg::SYM_W-1:0] sj;
		logic                       ui;
		logic                       uj;
		sym_bad = 1'b0;
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			si = sirt_pkg::symbol_at(alpha, sirt_pkg::SYM_IDX_W'(i));
			ui = sirt_pkg::RADIX_W'(i) < radix_q;
			if (ui && (si == '0 || si == sirt_pkg::CH_PLUS || si == sirt_pkg::CH_MINUS))
				sym_bad = 1'b1;
			for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
				sj = sirt_pkg::symbol_at(alpha, sirt_pkg::SYM_IDX_W'(j));
				uj = sirt_pkg::RADIX_W'(j) < radix_q;
				if (ui && uj && si == sj)
					sym_bad = 1'b1;
			end
		end
	end

	assign alpha_ok = (radix_q >= sirt_pkg::RADIX_W'(2))
		&& (radix_q <= sirt_pkg::RADIX_W'(MAX_SYMBOLS)) && !sym_bad;

endmodule

`default_nettype wire

// ----- sv/sirt_ctrl.sv -----
// Controller FSM: sequences load, digit division, sign and digit emission, or the reject result.
// Depends on sirt_pkg; drives sirt_dp through dp_cmd_t.
`default_nettype none

module sirt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               alpha_ok,
	input  wire sirt_pkg::dp_stat_t stat,
	output sirt_pkg::dp_cmd_t       cmd,
	output logic                    busy
);

	sirt_pkg::state_t              state_q;
	sirt_pkg::state_t              state_nx;
	logic [sirt_pkg::GRP_W-1:0]    grp_q;
	logic                          grp_end;

	assign grp_end = grp_q == sirt_pkg::GRP_W'(sirt_pkg::STEPS_PER_DIGIT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sirt_pkg::ST_IDLE;
			grp_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == sirt_pkg::ST_DIVIDE)
				grp_q <= grp_q + 1'b1;
			else
				grp_q <= '0;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sirt_pkg::ST_IDLE: begin
				if (start)
					state_nx = alpha_ok ? sirt_pkg::ST_DIVIDE : sirt_pkg::ST_REJECT;
			end
			sirt_pkg::ST_DIVIDE: begin
				if (grp_end && stat.div_last)
					state_nx = stat.neg ? sirt_pkg::ST_SIGN : sirt_pkg::ST_DIGITS;
			end
			sirt_pkg::ST_SIGN:   state_nx = sirt_pkg::ST_DIGITS;
			sirt_pkg::ST_DIGITS: begin
				if (stat.emit_last)
					state_nx = sirt_pkg::ST_IDLE;
			end
			sirt_pkg::ST_REJECT: state_nx = sirt_pkg::ST_IDLE;
			default:             state_nx = sirt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			sirt_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			sirt_pkg::ST_DIVIDE: begin
				cmd.div_step  = 1'b1;
				cmd.digit_end = grp_end;
			end
			sirt_pkg::ST_SIGN:   cmd.emit_sign = 1'b1;
			sirt_pkg::ST_DIGITS: cmd.emit_digit = 1'b1;
			sirt_pkg::ST_REJECT: cmd.emit_bad = 1'b1;
			default:             busy = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/sirt_dp.sv -----
// Datapath: magnitude register, 8-bit-per-cycle radix divider, digit store,
// symbol lookup and result registers. Depends on sirt_pkg.
`default_nettype none

module sirt_dp #(
	parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sirt_pkg::dp_cmd_t              cmd,
	input  wire logic [sirt_pkg::NUM_W-1:0]     number,
	input  wire logic [sirt_pkg::RADIX_W-1:0]   radix,
	input  wire logic [sirt_pkg::ALPHA_W-1:0]   alpha,
	output sirt_pkg::dp_stat_t                  stat,
	output logic                                strobe,
	output logic      [sirt_pkg::SYM_W-1:0]     text_char,
	output logic                                last_char,
	output logic                                bad_alphabet
);

	localparam int DIG_W = $clog2(MAX_SYMBOLS);
	localparam int CMP_W = sirt_pkg::RADIX_W + 1;

	logic [sirt_pkg::NUM_W-1:0]         w_q;
	logic [DIG_W-1:0]                   rem_q;
	logic [sirt_pkg::CNT_W-1:0]         cnt_q;
	logic                               neg_q;
	logic [DIG_W-1:0]                   store_q [sirt_pkg::STORE_DEPTH];

	logic [sirt_pkg::NUM_W-1:0]         w_nx;
	logic [DIG_W-1:0]                   rem_nx;
	logic [sirt_pkg::STORE_AW-1:0]      rd_idx;
	logic [DIG_W-1:0]                   rd_digit;

	logic                               strobe_q;
	logic [sirt_pkg::SYM_W-1:0]         char_q;
	logic                               last_q;
	logic                               bad_q;

	// restoring division by radix, 8 quotient bits per cycle; the work register
	// shifts left and collects quotient bits at the bottom
	always_comb begin
		logic [DIG_W-1:0]                  r;
		logic [DIG_W:0]                    t;
		logic [CMP_W-1:0]                  diff;
		logic [sirt_pkg::BITS_PER_STEP-1:0] qb;
		r  = rem_q;
		qb = '0;
		for (int k = 0; k < sirt_pkg::BITS_PER_STEP; k++) begin
			t    = {r, w_q[sirt_pkg::NUM_W-1-k]};
			diff = CMP_W'(t) - CMP_W'(radix);
			if (CMP_W'(t) >= CMP_W'(radix)) begin
				qb[sirt_pkg::BITS_PER_STEP-1-k] = 1'b1;
				r = diff[DIG_W-1:0];
			end else begin
				r = t[DIG_W-1:0];
			end
		end
		rem_nx = r;
		w_nx   = {w_q[sirt_pkg::NUM_W-sirt_pkg::BITS_PER_STEP-1:0], qb};
	end

	assign rd_idx   = cnt_q[sirt_pkg::STORE_AW-1:0] - 1'b1;
	assign rd_digit = store_q[rd_idx];

	assign stat.neg       = neg_q;
	assign stat.div_last  = (w_nx == '0)
		|| (cnt_q == sirt_pkg::CNT_W'(sirt_pkg::STORE_DEPTH - 1));
	assign stat.emit_last = cnt_q == sirt_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			w_q   <= number[sirt_pkg::NUM_W-1] ? sirt_pkg::NUM_W'(0) - number : number;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			w_q <= w_nx;
			if (cmd.digit_end)
				cnt_q <= cnt_q + 1'b1;
		end else if (cmd.emit_digit) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= number[sirt_pkg::NUM_W-1];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= cmd.digit_end ? '0 : rem_nx;
		end
		if (cmd.div_step && cmd.digit_end)
			store_q[cnt_q[sirt_pkg::STORE_AW-1:0]] <= rem_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.emit_sign || cmd.emit_digit || cmd.emit_bad;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= sirt_pkg::CH_MINUS;
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sirt_pkg::symbol_at(alpha, sirt_pkg::SYM_IDX_W'(rd_digit));
			last_q <= stat.emit_last;
			bad_q  <= 1'b0;
		end else if (cmd.emit_bad) begin
			char_q <= '0;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end
	end

	assign strobe       = strobe_q;
	assign text_char    = char_q;
	assign last_char    = last_q;
	assign bad_alphabet = bad_q;

endmodule

`default_nettype wire

// ----- sv/sirt_checker.sv -----
// Port-level checks on result framing for the radix text converter.
// Depends on sirt_pkg; bound to signed_integer_to_radix_text.
`default_nettype none

module sirt_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         strobe,
	input wire logic [sirt_pkg::SYM_W-1:0]   text_char,
	input wire logic                         last_char,
	input wire logic                         bad_alphabet
);

	// results only come out of a request in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("strobe without a request in progress");

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && bad_alphabet |-> last_char && text_char == '0)
		else $error("invalid result is not a single zero character");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("strobe right after a request");

	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_char |=> strobe)
		else $error("gap inside one number's text");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_char |=> !strobe)
		else $error("character after the final one");

endmodule

bind signed_integer_to_radix_text sirt_checker u_sirt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.strobe       (strobe),
	.text_char    (text_char),
	.last_char    (last_char),
	.bad_alphabet (bad_alphabet)
);

`default_nettype wire
